[design/assert_macros.svh]
// assertion macros shared by the group dot accumulator rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/igda_pkg.sv]
`timescale 1ns / 1ps
// types and constants of the int4 x int8 group dot accumulator
// no dependencies; used by igda_lane, igda_fpu and the top level
package igda_pkg;

    // tile geometry
    localparam int COLS         = 8;
    localparam int NIB_PER_LANE = 4;
    localparam int CNT_W        = 3;
    localparam int COL_W        = 3;
    localparam logic [CNT_W-1:0] LAST_CHUNK = 3'd7;
    localparam logic [3:0] COLS_MAX = 4'd8;

    // fp32 codes
    localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;

    // fused multiply-add unit datapath sizes
    localparam int ALIGN_W = 76;
    localparam int EXP_W   = 12;

    typedef struct packed {
        logic        start;
        logic        int_mode;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] ival;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] result;
    } fpu_rsp_t;

endpackage

[design/igda_lane.sv]
`timescale 1ns / 1ps
// one column lane: four nibble x byte products added into a wrapping int32 dot sum
// depends on igda_pkg
module igda_lane (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        first,
    input  logic [31:0] seed,
    input  logic [31:0] act_word,
    input  logic [15:0] nibbles,
    output logic [31:0] dot
);
    import igda_pkg::*;

    logic [31:0]        dot_reg;
    logic [31:0]        dot_next;
    logic signed [14:0] term_sum;

    // sum of the four products of this chunk
    always_comb
    begin
        logic signed [4:0]  nib_s;
        logic signed [7:0]  act_s;
        logic signed [12:0] prod;
        term_sum = '0;
        for (int t = 0; t < NIB_PER_LANE; t++)
        begin
            nib_s    = $signed({1'b0, nibbles[4*t +: 4]});
            act_s    = $signed(act_word[8*t +: 8]);
            prod     = 13'(nib_s * act_s);
            term_sum = term_sum + 15'(prod);
        end
    end

    // seed on the group's first chunk, then accumulate modulo 2^32
    always_comb
    begin
        dot_next = dot_reg;
        if (load)
        begin
            dot_next = (first ? seed : dot_reg) + 32'(term_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

[design/igda_fpu.sv]
`timescale 1ns / 1ps
// multi-cycle fp32 fused multiply-add with one rounding (nearest even), also
// converts int32 to fp32 and multiplies when the addend is -0; depends on igda_pkg
module igda_fpu (
    input  logic                clk,
    input  logic                rst_n,
    input  igda_pkg::fpu_req_t  req,
    output igda_pkg::fpu_rsp_t  rsp
);
    import igda_pkg::*;

    localparam int W    = ALIGN_W;
    localparam int EW   = EXP_W;
    localparam int SH_W = $clog2(W + 1);
    localparam logic signed [EW-1:0] E_MIN   = -12'sd126;
    localparam logic signed [EW-1:0] W_S     = EW'(W);
    localparam logic signed [EW-1:0] BIAS    = 12'sd127;
    localparam logic signed [EW-1:0] E_OFF   = 12'sd150;
    localparam logic signed [EW-1:0] E_MAXB  = 12'sd255;

    typedef enum logic [5:0] {
        FS_IDLE  = 6'b000001,
        FS_PREP  = 6'b000010,
        FS_ALIGN = 6'b000100,
        FS_ADD   = 6'b001000,
        FS_NORM  = 6'b010000,
        FS_ROUND = 6'b100000
    } fs_t;

    fs_t                 state_reg, state_next;
    logic                done_reg, done_next;
    logic [31:0]         result_reg, result_next;
    logic [47:0]         mp_reg, mp_next;
    logic signed [EW-1:0] ep_reg, ep_next;
    logic [23:0]         mc_reg, mc_next;
    logic signed [EW-1:0] ec_reg, ec_next;
    logic                ps_reg, ps_next;
    logic                cs_reg, cs_next;
    logic                cz_reg, cz_next;
    logic [W-1:0]        big_reg, big_next;
    logic [W-1:0]        small_reg, small_next;
    logic                sub_reg, sub_next;
    logic                sign_reg, sign_next;
    logic [W-1:0]        r_reg, r_next;
    logic signed [EW-1:0] et_reg, et_next;

    // operand decode
    logic [7:0]  a_e, b_e, c_e;
    logic        a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
    logic [23:0] ma, mb, mc;
    logic signed [EW-1:0] ea, eb, ec;
    logic [31:0] ival_mag;
    logic        p_sign, p_zero, p_inf, any_nan;
    logic [47:0] p_mant;
    logic signed [EW-1:0] p_exp;

    always_comb
    begin
        a_e    = req.a[30:23];
        b_e    = req.b[30:23];
        c_e    = req.c[30:23];
        a_zero = (a_e == 8'h00) && (req.a[22:0] == '0);
        b_zero = (b_e == 8'h00) && (req.b[22:0] == '0);
        c_zero = (c_e == 8'h00) && (req.c[22:0] == '0);
        a_inf  = (a_e == 8'hFF) && (req.a[22:0] == '0);
        b_inf  = (b_e == 8'hFF) && (req.b[22:0] == '0);
        c_inf  = (c_e == 8'hFF) && (req.c[22:0] == '0);
        a_nan  = (a_e == 8'hFF) && (req.a[22:0] != '0);
        b_nan  = (b_e == 8'hFF) && (req.b[22:0] != '0);
        c_nan  = (c_e == 8'hFF) && (req.c[22:0] != '0);
        ma     = {a_e != 8'h00, req.a[22:0]};
        mb     = {b_e != 8'h00, req.b[22:0]};
        mc     = {c_e != 8'h00, req.c[22:0]};
        ea     = $signed({4'b0, (a_e == 8'h00) ? 8'd1 : a_e}) - E_OFF;
        eb     = $signed({4'b0, (b_e == 8'h00) ? 8'd1 : b_e}) - E_OFF;
        ec     = $signed({4'b0, (c_e == 8'h00) ? 8'd1 : c_e}) - E_OFF;
        ival_mag = req.ival[31] ? (32'd0 - req.ival) : req.ival;
        if (req.int_mode)
        begin
            p_sign  = req.ival[31];
            p_zero  = (req.ival == '0);
            p_inf   = 1'b0;
            p_mant  = {16'd0, ival_mag};
            p_exp   = '0;
            any_nan = c_nan;
        end
        else
        begin
            p_sign  = req.a[31] ^ req.b[31];
            p_zero  = a_zero || b_zero;
            p_inf   = a_inf || b_inf;
            p_mant  = ma * mb;
            p_exp   = ea + eb;
            any_nan = a_nan || b_nan || c_nan || (a_inf && b_zero) || (a_zero && b_inf);
        end
        if (p_inf && c_inf && (p_sign != req.c[31]))
        begin
            any_nan = 1'b1;
        end
    end

    // alignment of the smaller operand with a sticky bit at bit 0
    logic signed [EW-1:0] tp, tc, dmag;
    logic                 p_big;
    logic [SH_W-1:0]      shamt;
    logic [W-1:0]         p_place, c_place, big_pre, small_pre;
    logic [2*W-1:0]       wide;

    always_comb
    begin
        tp      = ep_reg + 12'sd47;
        tc      = ec_reg + 12'sd23;
        p_big   = cz_reg || (tp >= tc);
        dmag    = p_big ? (tp - tc) : (tc - tp);
        shamt   = (dmag > W_S) ? SH_W'(W) : dmag[SH_W-1:0];
        p_place = {1'b0, mp_reg, {(W-49){1'b0}}};
        c_place = cz_reg ? '0 : {1'b0, mc_reg, {(W-25){1'b0}}};
        big_pre   = p_big ? p_place : c_place;
        small_pre = p_big ? c_place : p_place;
        wide    = {small_pre, {W{1'b0}}} >> shamt;
    end

    // add or subtract magnitudes
    logic [W:0] sum_w, neg_w;

    always_comb
    begin
        sum_w = sub_reg ? ({1'b0, big_reg} - {1'b0, small_reg})
                        : ({1'b0, big_reg} + {1'b0, small_reg});
        neg_w = (W+1)'(0) - sum_w;
    end

    // right shift into the subnormal range
    logic signed [EW-1:0] rsh;
    logic [SH_W-1:0]      rsh_amt;
    logic [2*W-1:0]       rwide;

    always_comb
    begin
        rsh     = E_MIN - et_reg;
        rsh_amt = (rsh > W_S) ? SH_W'(W) : rsh[SH_W-1:0];
        rwide   = {r_reg, {W{1'b0}}} >> rsh_amt;
    end

    // round to nearest even and pack
    logic [23:0] rm;
    logic        rg, rs, rinc;
    logic [24:0] rsum;
    logic [23:0] rfin;
    logic signed [EW-1:0] ebias;
    logic [31:0] packed_res;

    always_comb
    begin
        rm    = r_reg[W-1 -: 24];
        rg    = r_reg[W-25];
        rs    = |r_reg[W-26:0];
        rinc  = rg && (rs || rm[0]);
        rsum  = {1'b0, rm} + 25'(rinc);
        rfin  = rsum[24] ? rsum[24:1] : rsum[23:0];
        ebias = et_reg + BIAS + (rsum[24] ? 12'sd1 : 12'sd0);
        if (r_reg == '0)
        begin
            packed_res = FP_POS_ZERO;
        end
        else if (!rfin[23])
        begin
            packed_res = {sign_reg, 8'h00, rfin[22:0]};
        end
        else if (ebias >= E_MAXB)
        begin
            packed_res = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            packed_res = {sign_reg, ebias[7:0], rfin[22:0]};
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mp_next     = mp_reg;
        ep_next     = ep_reg;
        mc_next     = mc_reg;
        ec_next     = ec_reg;
        ps_next     = ps_reg;
        cs_next     = cs_reg;
        cz_next     = cz_reg;
        big_next    = big_reg;
        small_next  = small_reg;
        sub_next    = sub_reg;
        sign_next   = sign_reg;
        r_next      = r_reg;
        et_next     = et_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (req.start)
                begin
                    mp_next = p_mant;
                    ep_next = p_exp;
                    mc_next = mc;
                    ec_next = ec;
                    ps_next = p_sign;
                    cs_next = req.c[31];
                    cz_next = c_zero;
                    if (any_nan)
                    begin
                        result_next = FP_QNAN;
                        done_next   = 1'b1;
                    end
                    else if (p_inf)
                    begin
                        result_next = {p_sign, 8'hFF, 23'd0};
                        done_next   = 1'b1;
                    end
                    else if (c_inf)
                    begin
                        result_next = req.c;
                        done_next   = 1'b1;
                    end
                    else if (p_zero)
                    begin
                        result_next = c_zero ? {p_sign & req.c[31], 31'd0} : req.c;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = FS_PREP;
                    end
                end
            end
            FS_PREP:
            begin
                // bring both significands to a leading one, one bit a cycle
                if (!mp_reg[47])
                begin
                    mp_next = {mp_reg[46:0], 1'b0};
                    ep_next = ep_reg - 12'sd1;
                end
                if (!cz_reg && !mc_reg[23])
                begin
                    mc_next = {mc_reg[22:0], 1'b0};
                    ec_next = ec_reg - 12'sd1;
                end
                if (mp_reg[47] && (cz_reg || mc_reg[23]))
                begin
                    state_next = FS_ALIGN;
                end
            end
            FS_ALIGN:
            begin
                big_next   = big_pre;
                small_next = {wide[2*W-1:W+1], wide[W] | (|wide[W-1:0])};
                sub_next   = !cz_reg && (ps_reg != cs_reg);
                sign_next  = p_big ? ps_reg : cs_reg;
                et_next    = (p_big ? tp : tc) + 12'sd1;
                state_next = FS_ADD;
            end
            FS_ADD:
            begin
                if (sub_reg && sum_w[W])
                begin
                    r_next    = neg_w[W-1:0];
                    sign_next = !sign_reg;
                end
                else
                begin
                    r_next = sum_w[W-1:0];
                end
                state_next = FS_NORM;
            end
            FS_NORM:
            begin
                if (r_reg == '0)
                begin
                    state_next = FS_ROUND;
                end
                else if (et_reg < E_MIN)
                begin
                    r_next  = {rwide[2*W-1:W+1], rwide[W] | (|rwide[W-1:0])};
                    et_next = E_MIN;
                end
                else if (!r_reg[W-1] && (et_reg > E_MIN))
                begin
                    r_next  = {r_reg[W-2:0], 1'b0};
                    et_next = et_reg - 12'sd1;
                end
                else
                begin
                    state_next = FS_ROUND;
                end
            end
            FS_ROUND:
            begin
                result_next = packed_res;
                done_next   = 1'b1;
                state_next  = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        mp_reg     <= mp_next;
        ep_reg     <= ep_next;
        mc_reg     <= mc_next;
        ec_reg     <= ec_next;
        ps_reg     <= ps_next;
        cs_reg     <= cs_next;
        cz_reg     <= cz_next;
        big_reg    <= big_next;
        small_reg  <= small_next;
        sub_reg    <= sub_next;
        sign_reg   <= sign_next;
        r_reg      <= r_next;
        et_reg     <= et_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.busy   = (state_reg != FS_IDLE);
    assign rsp.result = result_reg;

endmodule

[design/int4_int8_group_dot_accumulator_top.sv]
`timescale 1ns / 1ps
// top level of the int4 x int8 group dot accumulator: eight dot lanes and the
// float merge sequencer; depends on igda_pkg, igda_lane, igda_fpu, assert_macros.svh
//
// Usage:
//   input channel (in_valid / in_ready): one chunk per item, 4 activation bytes and
//   16 packed weight bytes; eight chunks make one 32-element group. The chunks of a
//   group are taken one per cycle; the eight dot lanes update in the accepting cycle.
//   After the eighth chunk in_ready drops while the shared fma unit runs three passes
//   per column (scale product, int to float, fused update), columns in turn. A pass
//   skips the datapath when an operand is zero, inf or nan; the conversion shifts
//   out each leading zero of the dot sum, and subnormals or cancellation lengthen
//   a pass with long shifts.
//   output channel (out_valid / out_ready): on the row's last group, one item per
//   column in use, column 0 first, last_column set on the final one. Results leave
//   through an output register at up to one per cycle; a stalled receiver holds the
//   current item and the block waits in the emit phase, then the accumulators clear.
//   The held final item does not block new chunks.
//   reset: dot sums and float accumulators clear to zero, chunk count to 0, no item
//   is pending on the output.
`include "assert_macros.svh"

module int4_int8_group_dot_accumulator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        act_word,
    input  logic [63:0]        weight_low_half,
    input  logic [63:0]        weight_high_half,
    input  logic signed [12:0] act_group_sum,
    input  logic [31:0]        act_scale,
    input  logic [31:0]        column_scale,
    input  logic               last_group,
    input  logic [3:0]         columns_in_use,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         column_index,
    output logic [31:0]        sum_value,
    output logic               last_column
);
    import igda_pkg::*;

    typedef enum logic [4:0] {
        ST_RUN  = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_CVT  = 5'b00100,
        ST_FMA  = 5'b01000,
        ST_EMIT = 5'b10000
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] emit_reg, emit_next;
    logic             pend_reg, pend_next;
    logic             last_reg, last_next;
    logic [3:0]       ncols_reg, ncols_next;
    logic [31:0]      ascale_reg, ascale_next;
    logic [31:0]      sc_reg, sc_next;
    logic [31:0]      v_reg, v_next;
    logic [31:0]      acc_reg [COLS];
    logic [31:0]      acc_next [COLS];
    logic [31:0]      scale_mem [COLS];
    logic             ovalid_reg, ovalid_next;
    logic [2:0]       ocol_reg, ocol_next;
    logic [31:0]      osum_reg, osum_next;
    logic             olast_reg, olast_next;

    logic             accept;
    logic [127:0]     weights;
    logic [31:0]      seed;
    logic [31:0]      dot_w [COLS];
    logic [3:0]       ncols_sat;
    fpu_req_t         fpu_req;
    fpu_rsp_t         fpu_rsp;

    assign in_ready = (state_reg == ST_RUN);
    assign accept   = in_valid && in_ready;
    assign weights  = {weight_high_half, weight_low_half};
    assign seed     = 32'd0 - (32'(act_group_sum) << 3);
    assign ncols_sat = (columns_in_use > COLS_MAX) ? COLS_MAX : columns_in_use;

    // dot lanes, one per column
    for (genvar g = 0; g < COLS; g++)
    begin : g_lane
        igda_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (accept),
            .first    (cnt_reg == '0),
            .seed     (seed),
            .act_word (act_word),
            .nibbles  (weights[16*g +: 16]),
            .dot      (dot_w[g])
        );
    end

    // shared fused multiply-add unit
    igda_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    // column scales, written one per chunk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scale_mem[cnt_reg] <= column_scale;
        end
    end

    // operand selection for the fma unit
    always_comb
    begin
        fpu_req.start    = 1'b0;
        fpu_req.int_mode = 1'b0;
        fpu_req.a        = scale_mem[col_reg];
        fpu_req.b        = ascale_reg;
        fpu_req.c        = FP_NEG_ZERO;
        fpu_req.ival     = dot_w[col_reg];
        case (state_reg)
            ST_MUL:
            begin
                fpu_req.start = !pend_reg;
            end
            ST_CVT:
            begin
                fpu_req.start    = !pend_reg;
                fpu_req.int_mode = 1'b1;
            end
            ST_FMA:
            begin
                fpu_req.start = !pend_reg;
                fpu_req.a     = v_reg;
                fpu_req.b     = sc_reg;
                fpu_req.c     = acc_reg[col_reg];
            end
            default:
            begin
                fpu_req.start = 1'b0;
            end
        endcase
    end

    // group sequencer and output register
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        col_next    = col_reg;
        emit_next   = emit_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        ncols_next  = ncols_reg;
        ascale_next = ascale_reg;
        sc_next     = sc_reg;
        v_next      = v_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ocol_next   = ocol_reg;
        osum_next   = osum_reg;
        olast_next  = olast_reg;
        if (fpu_req.start)
        begin
            pend_next = 1'b1;
        end
        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CHUNK)
                    begin
                        last_next   = last_group;
                        ncols_next  = ncols_sat;
                        ascale_next = act_scale;
                        col_next    = '0;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (fpu_rsp.done)
                begin
                    sc_next    = fpu_rsp.result;
                    pend_next  = 1'b0;
                    state_next = ST_CVT;
                end
            end
            ST_CVT:
            begin
                if (fpu_rsp.done)
                begin
                    v_next     = fpu_rsp.result;
                    pend_next  = 1'b0;
                    state_next = ST_FMA;
                end
            end
            ST_FMA:
            begin
                if (fpu_rsp.done)
                begin
                    acc_next[col_reg] = fpu_rsp.result;
                    pend_next         = 1'b0;
                    col_next          = col_reg + 1'b1;
                    if (col_reg != COL_W'(COLS - 1))
                    begin
                        state_next = ST_MUL;
                    end
                    else if (!last_reg)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (ncols_reg == '0)
                    begin
                        // nothing to emit, clear the run anyway
                        for (int j = 0; j < COLS; j++)
                        begin
                            acc_next[j] = FP_POS_ZERO;
                        end
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        emit_next  = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ocol_next   = emit_reg;
                    osum_next   = acc_reg[emit_reg];
                    olast_next  = ({1'b0, emit_reg} == (ncols_reg - 4'd1));
                    emit_next   = emit_reg + 1'b1;
                    if ({1'b0, emit_reg} == (ncols_reg - 4'd1))
                    begin
                        for (int j = 0; j < COLS; j++)
                        begin
                            acc_next[j] = FP_POS_ZERO;
                        end
                        emit_next  = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            cnt_reg    <= '0;
            col_reg    <= '0;
            emit_reg   <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int j = 0; j < COLS; j++)
            begin
                acc_reg[j] <= FP_POS_ZERO;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            col_reg    <= col_next;
            emit_reg   <= emit_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            acc_reg    <= acc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        ncols_reg  <= ncols_next;
        ascale_reg <= ascale_next;
        sc_reg     <= sc_next;
        v_reg      <= v_next;
        ocol_reg   <= ocol_next;
        osum_reg   <= osum_next;
        olast_reg  <= olast_next;
    end

    assign out_valid    = ovalid_reg;
    assign column_index = ocol_reg;
    assign sum_value    = osum_reg;
    assign last_column  = olast_reg;

    // checks
    `ASSERT_NEXT(a_float_after_group, accept && (cnt_reg == LAST_CHUNK), !in_ready,
        "eighth chunk did not start the float phase")
    `ASSERT_IMPLIES(a_done_pending, fpu_rsp.done, pend_reg,
        "fma result arrived with no pass pending")
    `ASSERT_IMPLIES(a_count_idle, !in_ready, cnt_reg == '0,
        "chunk count not at group start while input is held off")

endmodule
